FILE: hdl/brct_pkg.sv
package brct_pkg;

   localparam int MAX_CHILDREN = 64;
   localparam int CHILD_WIDTH  = 32;
   localparam int WORD_COUNT   = 4;
   localparam int WORD_W       = 64;
   localparam int WSEL_W       = 2;
   localparam int BIT_W        = 6;
   localparam int KEY_W        = 8;
   localparam int SLOT_W       = 6;
   localparam int COUNT_W      = 7;
   localparam int TYPE_W       = 3;
   localparam int STATUS_W     = 3;

   localparam logic [TYPE_W-1:0] REQ_FIND   = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_ADD    = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_REMOVE = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_FIRST  = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_LAST   = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_ENUM   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

   function automatic logic [COUNT_W-1:0] ones_count(input logic [WORD_W-1:0] v);
      logic [COUNT_W-1:0] c;
      c = '0;
      for (int i = 0; i < WORD_W; i++) begin
         c = c + COUNT_W'(v[i]);
      end
      return c;
   endfunction

endpackage

FILE: hdl/brct_req_if.sv
interface brct_req_if import brct_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [TYPE_W-1:0]      req_type;
   logic [KEY_W-1:0]       key_byte;
   logic [CHILD_WIDTH-1:0] child_value;

   modport source (output valid, output req_type, output key_byte, output child_value,
                   input ready);
   modport sink (input valid, input req_type, input key_byte, input child_value,
                 output ready);
endinterface

FILE: hdl/brct_rsp_if.sv
interface brct_rsp_if import brct_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [CHILD_WIDTH-1:0] out_child;
   logic [SLOT_W-1:0]      slot_index;
   logic [COUNT_W-1:0]     child_count;
   logic                   last_result;

   modport source (output valid, output status, output out_child, output slot_index,
                   output child_count, output last_result, input ready);
   modport sink (input valid, input status, input out_child, input slot_index,
                 input child_count, input last_result, output ready);
endinterface

FILE: hdl/brct_child_ram.sv
module brct_child_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bitmap_rank_child_table.sv
// A request is accepted, then ranked over each bitmap word from the lowest up to the
//   key's word, then decoded; then a child is read, or add/remove moves one entry per
//   cycle before its write, and then the result is registered. One request at a time;
//   the slowest are add into 63 children or remove from 64, lowest key in the top bitmap word.
// Enumerate emits one word per cycle while the result side is ready.
// Reset (synchronous, active high) clears the bitmap and the count; no memory sweep.
module bitmap_rank_child_table import brct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   brct_req_if.sink   req_ch,
   brct_rsp_if.source rsp_ch
);

   typedef enum logic [3:0] {
      S_IDLE, S_RANK, S_EXEC, S_READ, S_SHIFT_UP, S_INSERT,
      S_SHIFT_DN, S_DELETE, S_RESULT, S_ENUM
   } state_type;

   state_type                         state_ff;
   logic [TYPE_W-1:0]                 op_ff;
   logic [KEY_W-1:0]                  key_ff;
   logic [CHILD_WIDTH-1:0]            value_ff;
   logic [WSEL_W-1:0]                 word_ff;
   logic [COUNT_W-1:0]                rank_ff;
   logic [SLOT_W-1:0]                 idx_ff;
   logic [WORD_COUNT-1:0][WORD_W-1:0] presence_ff;
   logic [COUNT_W-1:0]                count_ff;
   logic [STATUS_W-1:0]               res_status_ff;
   logic [CHILD_WIDTH-1:0]            res_child_ff;
   logic [SLOT_W-1:0]                 res_slot_ff;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [CHILD_WIDTH-1:0] rsp_child_ff;
   logic [SLOT_W-1:0]      rsp_slot_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;
   logic                   rsp_last_ff;

   logic                   ram_wr_en;
   logic [SLOT_W-1:0]      ram_wr_addr;
   logic [CHILD_WIDTH-1:0] ram_wr_data;
   logic                   ram_rd_en;
   logic [SLOT_W-1:0]      ram_rd_addr;
   logic [CHILD_WIDTH-1:0] ram_rd_data;

   logic [WSEL_W-1:0]  key_word;
   logic [BIT_W-1:0]   key_bit;
   logic [WORD_W-1:0]  low_mask;
   logic [WORD_W-1:0]  rank_bits;
   logic [COUNT_W-1:0] rank_sum;
   logic               hit;
   logic               full;
   logic               empty;
   logic [SLOT_W-1:0]  slot;
   logic [SLOT_W-1:0]  last_slot;
   logic               out_free;
   logic               emit_word;
   logic               enum_last;
   logic               up_done;
   logic               dn_more;

   assign key_word  = key_ff[KEY_W-1:BIT_W];
   assign key_bit   = key_ff[BIT_W-1:0];
   assign low_mask  = (WORD_W'(1) << key_bit) - WORD_W'(1);
   assign rank_bits = (word_ff == key_word) ? (presence_ff[word_ff] & low_mask)
                                            : presence_ff[word_ff];
   assign rank_sum  = rank_ff + ones_count(rank_bits);
   assign hit       = presence_ff[key_word][key_bit];
   assign full      = (count_ff >= COUNT_W'(MAX_CHILDREN));
   assign empty     = (count_ff == '0);
   assign slot      = rank_ff[SLOT_W-1:0];
   assign last_slot = SLOT_W'(count_ff - COUNT_W'(1));
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign emit_word = out_free && (state_ff == S_RESULT || state_ff == S_ENUM);
   assign enum_last = ({1'b0, idx_ff} + COUNT_W'(1)) == count_ff;
   assign up_done   = (idx_ff - SLOT_W'(1)) == slot;
   assign dn_more   = ({1'b0, idx_ff} + COUNT_W'(2)) < count_ff;

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = ram_rd_data;
      unique case (state_ff)
         S_EXEC: begin
            case (op_ff) inside
               REQ_FIND: begin
                  ram_rd_en   = hit;
                  ram_rd_addr = slot;
               end
               REQ_ADD: begin
                  ram_rd_en   = !full && !hit && (count_ff > rank_ff);
                  ram_rd_addr = last_slot;
               end
               REQ_REMOVE: begin
                  ram_rd_en   = hit && !empty && ((rank_ff + COUNT_W'(1)) < count_ff);
                  ram_rd_addr = slot + SLOT_W'(1);
               end
               REQ_FIRST, REQ_ENUM: begin
                  ram_rd_en   = !empty;
                  ram_rd_addr = '0;
               end
               REQ_LAST: begin
                  ram_rd_en   = !empty;
                  ram_rd_addr = last_slot;
               end
               default: ;
            endcase
         end
         S_SHIFT_UP: begin
            ram_wr_en   = 1'b1;
            ram_rd_en   = !up_done;
            ram_rd_addr = idx_ff - SLOT_W'(2);
         end
         S_INSERT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = slot;
            ram_wr_data = value_ff;
         end
         S_SHIFT_DN: begin
            ram_wr_en   = 1'b1;
            ram_rd_en   = dn_more;
            ram_rd_addr = idx_ff + SLOT_W'(2);
         end
         S_ENUM: begin
            ram_rd_en   = out_free && !enum_last;
            ram_rd_addr = idx_ff + SLOT_W'(1);
         end
         default: ;
      endcase
   end

   brct_child_ram #(
      .DEPTH(MAX_CHILDREN),
      .WIDTH(CHILD_WIDTH)
   ) u_child_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         presence_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit_word || (rsp_valid_ff && !rsp_ch.ready);
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  op_ff    <= req_ch.req_type;
                  key_ff   <= req_ch.key_byte;
                  value_ff <= req_ch.child_value;
                  word_ff  <= '0;
                  rank_ff  <= '0;
                  state_ff <= S_RANK;
               end
            end
            S_RANK: begin
               rank_ff <= rank_sum;
               word_ff <= word_ff + WSEL_W'(1);
               if (word_ff == key_word) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               res_status_ff <= ST_OK;
               res_child_ff  <= '0;
               res_slot_ff   <= '0;
               state_ff      <= S_RESULT;
               case (op_ff) inside
                  REQ_FIND: begin
                     if (!hit) begin
                        res_status_ff <= ST_ABSENT;
                     end else begin
                        res_slot_ff <= slot;
                        state_ff    <= S_READ;
                     end
                  end
                  REQ_ADD: begin
                     if (full) begin
                        res_status_ff <= ST_FULL;
                     end else if (hit) begin
                        res_status_ff <= ST_PRESENT;
                     end else if (count_ff > rank_ff) begin
                        idx_ff   <= count_ff[SLOT_W-1:0];
                        state_ff <= S_SHIFT_UP;
                     end else begin
                        state_ff <= S_INSERT;
                     end
                  end
                  REQ_REMOVE: begin
                     if (!hit || empty) begin
                        res_status_ff <= ST_ABSENT;
                     end else if ((rank_ff + COUNT_W'(1)) < count_ff) begin
                        idx_ff   <= slot;
                        state_ff <= S_SHIFT_DN;
                     end else begin
                        state_ff <= S_DELETE;
                     end
                  end
                  REQ_FIRST, REQ_LAST: begin
                     if (empty) begin
                        res_status_ff <= ST_EMPTY;
                     end else begin
                        res_slot_ff <= (op_ff == REQ_FIRST) ? '0 : last_slot;
                        state_ff    <= S_READ;
                     end
                  end
                  REQ_ENUM: begin
                     if (empty) begin
                        res_status_ff <= ST_EMPTY;
                     end else begin
                        idx_ff   <= '0;
                        state_ff <= S_ENUM;
                     end
                  end
                  default: ;
               endcase
            end
            S_READ: begin
               res_child_ff <= ram_rd_data;
               state_ff     <= S_RESULT;
            end
            S_SHIFT_UP: begin
               idx_ff <= idx_ff - SLOT_W'(1);
               if (up_done) begin
                  state_ff <= S_INSERT;
               end
            end
            S_INSERT: begin
               presence_ff[key_word][key_bit] <= 1'b1;
               count_ff     <= count_ff + COUNT_W'(1);
               res_child_ff <= value_ff;
               res_slot_ff  <= slot;
               state_ff     <= S_RESULT;
            end
            S_SHIFT_DN: begin
               idx_ff <= idx_ff + SLOT_W'(1);
               if (!dn_more) begin
                  state_ff <= S_DELETE;
               end
            end
            S_DELETE: begin
               presence_ff[key_word][key_bit] <= 1'b0;
               count_ff    <= count_ff - COUNT_W'(1);
               res_slot_ff <= slot;
               state_ff    <= S_RESULT;
            end
            S_RESULT: begin
               if (out_free) begin
                  rsp_status_ff <= res_status_ff;
                  rsp_child_ff  <= res_child_ff;
                  rsp_slot_ff   <= res_slot_ff;
                  rsp_count_ff  <= count_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_ENUM: begin
               if (out_free) begin
                  rsp_status_ff <= ST_OK;
                  rsp_child_ff  <= ram_rd_data;
                  rsp_slot_ff   <= idx_ff;
                  rsp_count_ff  <= count_ff;
                  rsp_last_ff   <= enum_last;
                  idx_ff        <= idx_ff + SLOT_W'(1);
                  if (enum_last) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.out_child   = rsp_child_ff;
   assign rsp_ch.slot_index  = rsp_slot_ff;
   assign rsp_ch.child_count = rsp_count_ff;
   assign rsp_ch.last_result = rsp_last_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_CHILDREN))
      else $error("child count above capacity");

   a_bitmap_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> $countones(presence_ff) == count_ff)
      else $error("bitmap population differs from child count");

   a_shift_above_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT_UP |-> idx_ff > slot)
      else $error("upward shift passed the insert slot");

   a_accept_to_rank: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff == S_RANK)
      else $error("accepted word did not start ranking");

   a_enum_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ENUM && out_free && enum_last |=> state_ff == S_IDLE && rsp_last_ff)
      else $error("enumeration did not end on its last word");

endmodule
